// ----- sv/assert_macros.svh -----
// Assertion macros used by the decoder top level.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/drbd_pkg.sv -----
// Package of the dictionary/run bitstream decoder: constants, codes and
// the types passed between front end, command queue and back end.
package drbd_pkg;

    localparam int DICT_SIZE = 15;
    localparam logic [3:0] HDR_LAST  = 4'(DICT_SIZE);
    localparam logic [3:0] END_INDEX = 4'd15;
    localparam logic [3:0] RUN_BIAS  = 4'd2;
    localparam logic [3:0] LIT_BITS  = 4'd8;
    localparam logic [3:0] IDX_BITS  = 4'd4;
    localparam logic [3:0] CNT_BITS  = 4'd3;

    // Command queue geometry.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Parser phase between code bits.
    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_SECOND,
        PH_LITERAL,
        PH_INDEX,
        PH_COUNT,
        PH_RUNIDX
    } t_phase;

    // Kind of one emit operation.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LIT,
        OP_DICT
    } t_op_kind;

    // Back end sequencing state: which operation of a command is playing.
    typedef enum logic {
        BS_FIRST,
        BS_SECOND
    } t_bstate;

    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  value;   // literal byte, or dictionary index in [3:0]
        logic [3:0]  count;   // number of repeats, 1 to 9
    } t_op;

    typedef struct packed {
        t_op  op0;
        t_op  op1;
        logic ended;
    } t_cmd;

    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [7:0] data;
    } t_dict_wr;

    typedef struct packed {
        logic done;
        logic hdr_full;
    } t_front_status;

endpackage

// ----- sv/dictionary_run_bitstream_decoder.sv -----
// Dictionary/run bitstream decoder, top level. Depends on drbd_pkg, drbd_front,
// drbd_queue, drbd_back and assert_macros.svh.
//
// The first 15 bytes load the dictionary and give no results. Each later byte
// is parsed combinationally by the front end into one command of up to two
// emit operations, which waits in a two-entry queue. The back end plays a
// command out at one result per cycle while the output is not stalled, and a
// byte yields at most ten results; a byte that yields none, a header byte or a
// byte after the end code queues nothing. The input is stalled only while the
// command queue is full. Results of the byte holding the end code already
// carry stream_ended; later bytes are taken and dropped.
`include "assert_macros.svh"

module dictionary_run_bitstream_decoder import drbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_item,
    output logic       o_stream_ended
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    t_cmd          push_cmd;
    t_cmd          head_cmd;
    t_dict_wr      dict_wr;
    t_front_status front_status;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // Front end: header load and code parsing.
    drbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .o_dict_wr (dict_wr),
        .o_status  (front_status)
    );

    // Command queue between the two halves.
    drbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: dictionary lookup and result sequencing.
    drbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dict_wr      (dict_wr),
        .i_head         (head_cmd),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item),
        .o_stream_ended (o_stream_ended)
    );

    // A result flagged with stream_ended implies the parser has stopped.
    `ASSERT_IMPLIES(a_ended_implies_done, i_clk, i_rst_n, o_valid && o_stream_ended, front_status.done, "stream_ended shown before the parser saw the end code")
    // Commands are only queued once the dictionary is complete.
    `ASSERT_IMPLIES(a_push_after_header, i_clk, i_rst_n, push, front_status.hdr_full, "command queued during dictionary load")
    // Nothing is queued after the end code.
    `ASSERT_IMPLIES(a_no_push_when_done, i_clk, i_rst_n, front_status.done, !push, "command queued after the end code")
    // The back end never retires a command from an empty queue.
    `ASSERT_ALWAYS(a_pop_not_empty, i_clk, i_rst_n, !(pop && q_empty), "pop from empty command queue")

endmodule

// ----- sv/drbd_front.sv -----
// Front end of the decoder: loads the dictionary from header bytes and parses
// code bytes into emit commands. Depends on drbd_pkg.
module drbd_front import drbd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    output logic          o_push,
    output t_cmd          o_cmd,
    output t_dict_wr      o_dict_wr,
    output t_front_status o_status
);

    logic [3:0] r_hdr_cnt, n_hdr_cnt;
    t_phase     r_phase, n_phase;
    logic [3:0] r_taken, n_taken;
    logic [7:0] r_accum, n_accum;
    logic [3:0] r_run, n_run;
    logic       r_done, n_done;
    logic       hdr_full;
    logic       any_op;
    t_op        op0, op1;

    assign hdr_full = (r_hdr_cnt == HDR_LAST);

    // Walk the eight code bits of one byte, most significant first.
    always_comb begin
        logic [7:0] sh;
        logic       b;
        logic       slot;
        t_op        em;
        n_phase = r_phase;
        n_taken = r_taken;
        n_accum = r_accum;
        n_run   = r_run;
        n_done  = r_done;
        op0     = '{kind: OP_NONE, value: 8'd0, count: 4'd0};
        op1     = '{kind: OP_NONE, value: 8'd0, count: 4'd0};
        sh      = i_in_byte;
        slot    = 1'b0;
        for (int k = 0; k < 8; k++) begin
            b  = sh[7];
            sh = {sh[6:0], 1'b0};
            em = '{kind: OP_NONE, value: 8'd0, count: 4'd0};
            if (!n_done) begin
                unique case (n_phase)
                    PH_PREFIX: begin
                        n_phase = b ? PH_LITERAL : PH_SECOND;
                        n_taken = 4'd0;
                        n_accum = 8'd0;
                    end
                    PH_SECOND: begin
                        n_phase = b ? PH_COUNT : PH_INDEX;
                        n_taken = 4'd0;
                        n_accum = 8'd0;
                    end
                    PH_LITERAL, PH_INDEX, PH_COUNT, PH_RUNIDX: begin
                        n_accum = {n_accum[6:0], b};
                        n_taken = n_taken + 4'd1;
                        priority if (n_phase == PH_LITERAL && n_taken == LIT_BITS) begin
                            em      = '{kind: OP_LIT, value: n_accum, count: 4'd1};
                            n_phase = PH_PREFIX;
                            n_taken = 4'd0;
                            n_accum = 8'd0;
                        end else if (n_phase == PH_INDEX && n_taken == IDX_BITS) begin
                            if (n_accum[3:0] == END_INDEX) begin
                                n_done = 1'b1;
                            end else begin
                                em = '{kind: OP_DICT, value: n_accum, count: 4'd1};
                            end
                            n_phase = PH_PREFIX;
                            n_taken = 4'd0;
                            n_accum = 8'd0;
                        end else if (n_phase == PH_COUNT && n_taken == CNT_BITS) begin
                            n_run   = {1'b0, n_accum[2:0]} + RUN_BIAS;
                            n_phase = PH_RUNIDX;
                            n_taken = 4'd0;
                            n_accum = 8'd0;
                        end else if (n_phase == PH_RUNIDX && n_taken == IDX_BITS) begin
                            // A run of the end index repeats a zero byte.
                            if (n_accum[3:0] == END_INDEX) begin
                                em = '{kind: OP_LIT, value: 8'd0, count: n_run};
                            end else begin
                                em = '{kind: OP_DICT, value: n_accum, count: n_run};
                            end
                            n_phase = PH_PREFIX;
                            n_taken = 4'd0;
                            n_accum = 8'd0;
                        end else begin
                            n_phase = n_phase;
                        end
                    end
                    default: begin
                        n_phase = PH_PREFIX;
                        n_taken = 4'd0;
                        n_accum = 8'd0;
                    end
                endcase
            end
            // Place the emit into the first free operation slot.
            if (em.kind != OP_NONE) begin
                if (!slot) begin
                    op0  = em;
                    slot = 1'b1;
                end else begin
                    op1 = em;
                end
            end
        end
    end

    assign any_op = (op0.kind != OP_NONE);

    // Header byte count advances until the dictionary is full.
    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        if (i_accept && !r_done && !hdr_full) begin
            n_hdr_cnt = r_hdr_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= 4'd0;
            r_phase   <= PH_PREFIX;
            r_taken   <= 4'd0;
            r_accum   <= 8'd0;
            r_run     <= 4'd0;
            r_done    <= 1'b0;
        end else begin
            r_hdr_cnt <= n_hdr_cnt;
            if (i_accept && !r_done && hdr_full) begin
                r_phase <= n_phase;
                r_taken <= n_taken;
                r_accum <= n_accum;
                r_run   <= n_run;
                r_done  <= n_done;
            end
        end
    end

    assign o_dict_wr = '{en: i_accept && !r_done && !hdr_full, addr: r_hdr_cnt,
                         data: i_in_byte};
    assign o_push    = i_accept && !r_done && hdr_full && any_op;
    assign o_cmd     = '{op0: op0, op1: op1, ended: n_done};
    assign o_status  = '{done: r_done, hdr_full: hdr_full};

endmodule

// ----- sv/drbd_queue.sv -----
// Short command queue between the decoder front end and back end.
// Depends on drbd_pkg for the command type and depth.
module drbd_queue import drbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer wrap and occupancy.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- sv/drbd_back.sv -----
// Back end of the decoder: holds the dictionary and plays queued commands
// out one byte per transfer through an output register. Depends on drbd_pkg.
module drbd_back import drbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dict_wr   i_dict_wr,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_item,
    output logic       o_stream_ended
);

    logic [7:0] r_dict [DICT_SIZE];
    t_bstate    r_state, n_state;
    logic [3:0] r_rep, n_rep;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_ended;
    logic       load;
    t_op        cur;
    logic       op_done;
    logic       item_last;
    logic [7:0] cur_byte;

    // Dictionary written by header bytes; no reset.
    always_ff @(posedge i_clk) begin
        if (i_dict_wr.en) begin
            r_dict[i_dict_wr.addr] <= i_dict_wr.data;
        end
    end

    assign load      = !i_empty && (!r_valid || !i_stall);
    assign cur       = (r_state == BS_SECOND) ? i_head.op1 : i_head.op0;
    assign op_done   = ((r_rep + 4'd1) == cur.count);
    assign item_last = op_done && ((r_state == BS_SECOND) || (i_head.op1.kind == OP_NONE));
    assign cur_byte  = (cur.kind == OP_DICT) ? r_dict[cur.value[3:0]] : cur.value;

    // Next state: move to the second operation or back to the first.
    always_comb begin
        n_state = r_state;
        if (load && op_done) begin
            n_state = item_last ? BS_FIRST : BS_SECOND;
        end
    end

    // Outputs of the sequencer: repeat count and queue pop.
    always_comb begin
        n_rep = r_rep;
        o_pop = load && item_last;
        if (load) begin
            n_rep = op_done ? 4'd0 : r_rep + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_FIRST;
            r_rep   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rep   <= n_rep;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= cur_byte;
            r_last  <= item_last;
            r_ended <= i_head.ended;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_last_of_item = r_last;
    assign o_stream_ended = r_ended;

endmodule
